// ===== hw/rtl/detection_confirm_policy_unit_assert.svh =====
// ----------------------------------------------------------------------------
// detection confirm policy assertion macros
// concurrent checks for simulation, empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef DETECTION_CONFIRM_POLICY_UNIT_ASSERT_SVH
`define DETECTION_CONFIRM_POLICY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DCP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dcp assertion failed");

// next-cycle implication
`define DCP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dcp assertion failed");

`else

`define DCP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define DCP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/dcp_pkg.sv =====
// ----------------------------------------------------------------------------
// dcp_pkg
// shared types and constants of the detection confirm policy unit
// ----------------------------------------------------------------------------
package dcp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_THRESHOLD    = 3'd0;
    localparam logic [2:0] REG_CONFIRM_MODE = 3'd1;
    localparam logic [2:0] REG_WINDOW_N     = 3'd2;
    localparam logic [2:0] REG_NEEDED_K     = 3'd3;
    localparam logic [2:0] REG_COOLDOWN_LEN = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int THRESHOLD_W = 16;
    localparam int WINDOW_W    = 7;
    localparam int COOLDOWN_W  = 16;
    localparam int CONF_W      = 16;
    localparam int INDEX_W     = 32;
    localparam int TOTAL_W     = 32;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 120;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 16'd39322;
    localparam logic [WINDOW_W-1:0]    WINDOW_N_RST  = 7'd5;
    localparam logic [WINDOW_W-1:0]    NEEDED_K_RST  = 7'd5;
    localparam logic [COOLDOWN_W-1:0]  COOLDOWN_RST  = 16'd5;

    localparam logic MODE_ANY_OF_N = 1'b0;
    localparam logic MODE_K_OF_N   = 1'b1;

    // status from the history walker to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } hist_status_t;

endpackage

// ===== hw/rtl/dcp_hist.sv =====
// ----------------------------------------------------------------------------
// dcp_hist
// flag history memory with a serial walker that counts set flags
// ----------------------------------------------------------------------------
module dcp_hist #(
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic                  wr_flag,
    input  logic                  start,
    input  logic [CW-1:0]         scan_len,
    output dcp_pkg::hist_status_t status,
    output logic [CW-1:0]         flag_count
);

    logic             mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             rd_data_reg;
    logic             rd_vld_reg;

    logic             busy_reg;
    logic             pend_reg;
    logic [CW-1:0]    addr_reg;
    logic [CW-1:0]    len_reg;
    logic [CW-1:0]    cnt_reg;
    logic             rd_issue;
    logic             scan_done;
    logic [AW-1:0]    rd_addr;

    assign rd_addr   = addr_reg[AW-1:0];
    assign rd_issue  = busy_reg && (addr_reg < len_reg);
    assign scan_done = busy_reg && !rd_issue && !pend_reg;

    // entries never written read as zero through their valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_flag;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            addr_reg <= '0;
            len_reg  <= '0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            pend_reg <= 1'b0;
            addr_reg <= '0;
            len_reg  <= scan_len;
            cnt_reg  <= '0;
        end else begin
            pend_reg <= rd_issue;
            if (rd_issue) begin
                addr_reg <= addr_reg + CW'(1);
            end
            if (pend_reg) begin
                cnt_reg <= cnt_reg + CW'(rd_data_reg & rd_vld_reg);
            end
            if (scan_done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = scan_done;
    assign flag_count  = cnt_reg;

    `include "detection_confirm_policy_unit_assert.svh"

    `DCP_ASSERT_IMPL(a_cnt_within_len, aclk, aresetn, busy_reg, cnt_reg <= addr_reg)
    `DCP_ASSERT_IMPL(a_addr_within_len, aclk, aresetn, busy_reg, addr_reg <= len_reg)
    `DCP_ASSERT_NEXT(a_done_ends_walk, aclk, aresetn, scan_done && !start, !busy_reg)

endmodule

// ===== hw/rtl/detection_confirm_policy_unit.sv =====
// ----------------------------------------------------------------------------
// detection_confirm_policy_unit
// confirms classifier detections from a window of recent raw flags
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | content
//  s_        | in  | s_tvalid/s_tready  | confidence, sample index
//  m_        | out | m_tvalid/m_tready  | echoes, flags, running totals
//  cfg_      | in  | cfg_wr_en          | register index and write data
//
//  an item lasts as long as the serial walk over the filled part of the flag
//  history memory (64 entries by default), one entry per cycle
//  reset clears all history valid bits at once, no clearing pass
//  s_tready is high only while the sequencer idles
//  a result waiting on m_tready holds the sequencer before the next item
// ----------------------------------------------------------------------------
module detection_confirm_policy_unit #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // [15:0] confidence, [47:16] reading_index
    input  logic [dcp_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] confidence_out, [16] raw_flag, [17] confirmed, [49:18] index_out,
    // [81:50] inference_total, [113:82] confirmed_total, [119:114] zero
    output logic [dcp_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [dcp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dcp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int WW = (CW > dcp_pkg::WINDOW_W) ? CW : dcp_pkg::WINDOW_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // configuration
    logic [dcp_pkg::THRESHOLD_W-1:0] threshold_reg;
    logic                            mode_reg;
    logic [dcp_pkg::WINDOW_W-1:0]    window_n_reg;
    logic [dcp_pkg::WINDOW_W-1:0]    needed_k_reg;
    logic [dcp_pkg::COOLDOWN_W-1:0]  cooldown_len_reg;

    // policy state
    state_t                          state_reg, state_next;
    logic [AW-1:0]                   pos_reg;
    logic [CW-1:0]                   fill_reg;
    logic [dcp_pkg::COOLDOWN_W-1:0]  cool_reg;
    logic [dcp_pkg::TOTAL_W-1:0]     inf_total_reg;
    logic [dcp_pkg::TOTAL_W-1:0]     conf_total_reg;

    // item in flight
    logic [dcp_pkg::CONF_W-1:0]      item_conf_reg;
    logic [dcp_pkg::INDEX_W-1:0]     item_idx_reg;
    logic                            item_raw_reg;
    logic [CW-1:0]                   item_k_reg;
    logic                            cand_reg;

    // output register
    logic                            m_valid_reg;
    logic [dcp_pkg::M_TDATA_W-1:0]   m_data_reg;

    logic                            accept;
    logic [dcp_pkg::CONF_W-1:0]      in_conf;
    logic [dcp_pkg::INDEX_W-1:0]     in_idx;
    logic                            in_raw;
    logic [CW-1:0]                   n_eff;
    logic [WW-1:0]                   k_floor;
    logic [CW-1:0]                   k_eff;
    logic [AW-1:0]                   pos_sel;
    logic [CW-1:0]                   pos_inc;
    logic [AW-1:0]                   pos_next;
    logic [CW-1:0]                   fill_next;
    logic                            candidate;
    logic                            out_free;
    logic                            emit;
    logic                            conf_now;

    dcp_pkg::hist_status_t           hist_status;
    logic [CW-1:0]                   flag_count;

    assign in_conf = s_tdata[15:0];
    assign in_idx  = s_tdata[47:16];
    assign in_raw  = in_conf > threshold_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // window length and k clamped into range
    always_comb begin
        if (window_n_reg == '0) begin
            n_eff = CW'(1);
        end else if (WW'(window_n_reg) > WW'(HISTORY_DEPTH)) begin
            n_eff = CW'(HISTORY_DEPTH);
        end else begin
            n_eff = CW'(window_n_reg);
        end
        k_floor = (needed_k_reg == '0) ? WW'(1) : WW'(needed_k_reg);
        k_eff   = (k_floor > WW'(n_eff)) ? n_eff : CW'(k_floor);
    end

    // a write position outside a shrunk window restarts at zero
    always_comb begin
        pos_sel   = (CW'(pos_reg) >= n_eff) ? '0 : pos_reg;
        pos_inc   = CW'(pos_sel) + CW'(1);
        pos_next  = (pos_inc == n_eff) ? '0 : AW'(pos_inc);
        fill_next = (fill_reg >= n_eff) ? n_eff : fill_reg + CW'(1);
    end

    dcp_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (accept),
        .wr_addr    (pos_sel),
        .wr_flag    (in_raw),
        .start      (accept),
        .scan_len   (fill_next),
        .status     (hist_status),
        .flag_count (flag_count)
    );

    assign candidate = (mode_reg == dcp_pkg::MODE_K_OF_N) ? (flag_count >= item_k_reg)
                                                          : (flag_count != '0);
    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = (state_reg == ST_EMIT) && out_free;
    assign conf_now  = (cool_reg == '0) && cand_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hist_status.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= dcp_pkg::THRESHOLD_RST;
            mode_reg         <= dcp_pkg::MODE_ANY_OF_N;
            window_n_reg     <= dcp_pkg::WINDOW_N_RST;
            needed_k_reg     <= dcp_pkg::NEEDED_K_RST;
            cooldown_len_reg <= dcp_pkg::COOLDOWN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dcp_pkg::REG_THRESHOLD:    threshold_reg    <= cfg_wdata;
                dcp_pkg::REG_CONFIRM_MODE: mode_reg         <= cfg_wdata[0];
                dcp_pkg::REG_WINDOW_N:     window_n_reg     <= cfg_wdata[6:0];
                dcp_pkg::REG_NEEDED_K:     needed_k_reg     <= cfg_wdata[6:0];
                dcp_pkg::REG_COOLDOWN_LEN: cooldown_len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            fill_reg       <= '0;
            cool_reg       <= '0;
            inf_total_reg  <= '0;
            conf_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
            end
            if (emit) begin
                inf_total_reg <= inf_total_reg + 32'd1;
                if (cool_reg != '0) begin
                    cool_reg <= cool_reg - 16'd1;
                end else if (cand_reg) begin
                    cool_reg       <= cooldown_len_reg;
                    conf_total_reg <= conf_total_reg + 32'd1;
                end
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_conf_reg <= in_conf;
            item_idx_reg  <= in_idx;
            item_raw_reg  <= in_raw;
            item_k_reg    <= k_eff;
        end
        if (hist_status.done) begin
            cand_reg <= candidate;
        end
        if (emit) begin
            m_data_reg <= {6'd0,
                           conf_total_reg + {31'd0, conf_now},
                           inf_total_reg + 32'd1,
                           item_idx_reg,
                           conf_now,
                           item_raw_reg,
                           item_conf_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `include "detection_confirm_policy_unit_assert.svh"

    `DCP_ASSERT_IMPL(a_ready_walker_idle, aclk, aresetn, s_tready, !hist_status.busy)
    `DCP_ASSERT_NEXT(a_cooldown_reload, aclk, aresetn, emit && conf_now, cool_reg == $past(cooldown_len_reg))
    `DCP_ASSERT_NEXT(a_total_only_on_confirm, aclk, aresetn, emit && !conf_now, $stable(conf_total_reg))
    `DCP_ASSERT_NEXT(a_emit_fills_output, aclk, aresetn, emit, m_valid_reg && (state_reg == ST_IDLE))

endmodule

// ===== dv/detection_confirm_policy_checker.sv =====
// ----------------------------------------------------------------------------
// detection confirm policy checker
// watches the config port and both stream channels, keeps a shadow of the
// flag history, cooldown and totals, and compares every result transfer
// field by field against the oldest predicted decision
// ----------------------------------------------------------------------------
module detection_confirm_policy_checker #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [dcp_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [dcp_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [dcp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dcp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output int                                  pending_results,
    output int                                  mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // lowest field last so the struct lines up with m_tdata
    typedef struct packed {
        logic [5:0]                  pad;
        logic [dcp_pkg::TOTAL_W-1:0] confirmed_total;
        logic [dcp_pkg::TOTAL_W-1:0] inference_total;
        logic [dcp_pkg::INDEX_W-1:0] index_out;
        logic                        confirmed;
        logic                        raw_flag;
        logic [dcp_pkg::CONF_W-1:0]  confidence_out;
    } decision_t;

    // shadow of the configuration registers
    logic [dcp_pkg::THRESHOLD_W-1:0] thr_q;
    logic                            mode_q;
    logic [dcp_pkg::WINDOW_W-1:0]    win_q;
    logic [dcp_pkg::WINDOW_W-1:0]    kneed_q;
    logic [dcp_pkg::COOLDOWN_W-1:0]  cool_len_q;

    // shadow of the policy state
    bit                              flag_hist [HISTORY_DEPTH];
    int unsigned                     hist_pos;
    int unsigned                     hist_fill;
    logic [dcp_pkg::COOLDOWN_W-1:0]  cool_left;
    logic [dcp_pkg::TOTAL_W-1:0]     infer_total;
    logic [dcp_pkg::TOTAL_W-1:0]     confirm_total;

    decision_t                       expected_decisions [$];
    int                              fail_total = 0;

    assign mismatch_count = fail_total;

    function automatic decision_t predict_decision(
        logic [dcp_pkg::CONF_W-1:0]  conf,
        logic [dcp_pkg::INDEX_W-1:0] idx);
        decision_t   d;
        int unsigned n;
        int unsigned k;
        int unsigned p;
        int unsigned hits;
        logic        raw;
        logic        candidate;
        n = win_q;
        if (n < 1) n = 1;
        if (n > HISTORY_DEPTH) n = HISTORY_DEPTH;
        k = kneed_q;
        if (k < 1) k = 1;
        if (k > n) k = n;
        raw = (conf > thr_q);
        // a position left outside a shrunk window restarts at entry 0
        p = hist_pos;
        if (p >= n) p = 0;
        flag_hist[p] = raw;
        hist_pos = (p + 1) % n;
        if (hist_fill > n) hist_fill = n;
        if (hist_fill < n) hist_fill++;
        hits = 0;
        for (int i = 0; i < hist_fill; i++) begin
            if (flag_hist[i]) hits++;
        end
        candidate = (mode_q == dcp_pkg::MODE_ANY_OF_N) ? (hits > 0) : (hits >= k);
        d = '0;
        if (cool_left != 0) begin
            cool_left = cool_left - 1'b1;
        end else if (candidate) begin
            d.confirmed = 1'b1;
            cool_left = cool_len_q;
        end
        infer_total = infer_total + 1'b1;
        if (d.confirmed) confirm_total = confirm_total + 1'b1;
        d.confidence_out  = conf;
        d.raw_flag        = raw;
        d.index_out       = idx;
        d.inference_total = infer_total;
        d.confirmed_total = confirm_total;
        return d;
    endfunction

    task automatic compare_field(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin : watch
        decision_t want;
        decision_t got;
        if (!aresetn) begin
            thr_q         = dcp_pkg::THRESHOLD_RST;
            mode_q        = dcp_pkg::MODE_ANY_OF_N;
            win_q         = dcp_pkg::WINDOW_N_RST;
            kneed_q       = dcp_pkg::NEEDED_K_RST;
            cool_len_q    = dcp_pkg::COOLDOWN_RST;
            foreach (flag_hist[i]) flag_hist[i] = 1'b0;
            hist_pos      = 0;
            hist_fill     = 0;
            cool_left     = '0;
            infer_total   = '0;
            confirm_total = '0;
            expected_decisions.delete();
            pending_results <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    dcp_pkg::REG_THRESHOLD:
                        thr_q = cfg_wdata[dcp_pkg::THRESHOLD_W-1:0];
                    dcp_pkg::REG_CONFIRM_MODE:
                        mode_q = cfg_wdata[0];
                    dcp_pkg::REG_WINDOW_N:
                        win_q = cfg_wdata[dcp_pkg::WINDOW_W-1:0];
                    dcp_pkg::REG_NEEDED_K:
                        kneed_q = cfg_wdata[dcp_pkg::WINDOW_W-1:0];
                    dcp_pkg::REG_COOLDOWN_LEN:
                        cool_len_q = cfg_wdata[dcp_pkg::COOLDOWN_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_decisions.size() == 0) begin
                    $error("result transfer with no decision pending, m_tdata 0x%0h",
                           m_tdata);
                    fail_total++;
                end else begin
                    want = expected_decisions.pop_front();
                    got  = decision_t'(m_tdata);
                    compare_field("confidence_out", want.confidence_out,
                                  got.confidence_out);
                    compare_field("raw_flag", want.raw_flag, got.raw_flag);
                    compare_field("confirmed", want.confirmed, got.confirmed);
                    compare_field("index_out", want.index_out, got.index_out);
                    compare_field("inference_total", want.inference_total,
                                  got.inference_total);
                    compare_field("confirmed_total", want.confirmed_total,
                                  got.confirmed_total);
                    compare_field("pad", want.pad, got.pad);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_decisions.push_back(
                    predict_decision(s_tdata[dcp_pkg::CONF_W-1:0],
                                     s_tdata[dcp_pkg::CONF_W +: dcp_pkg::INDEX_W]));
            end
            pending_results <= expected_decisions.size();
        end
    end

endmodule

// ===== dv/detection_confirm_policy_unit_tb.sv =====
// ----------------------------------------------------------------------------
// detection confirm policy unit testbench
// drives confidence readings through directed register settings (reset
// values, zero and oversize window and k, zero and maximal cooldown, window
// shrunk at run time) and then random settings and bursty readings under
// several sender idle and receiver stall mixes; the checker predicts
// ----------------------------------------------------------------------------
module detection_confirm_policy_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [dcp_pkg::CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [dcp_pkg::CONF_W-1:0]     conf_word_t;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES  = 70;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_READINGS = 106;

    localparam logic [dcp_pkg::CONF_W-1:0] DIR_CONF [23] = '{
        16'h0000, 16'd39322, 16'd39323, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF,
        16'h0000, 16'h0001, 16'hFFFF, 16'h0000,
        16'hFFFF, 16'h1234, 16'h0000,
        16'h8001, 16'h8000, 16'h0000, 16'hFFFF, 16'h8001, 16'h8001, 16'h0000, 16'hC000
    };
    localparam logic [dcp_pkg::INDEX_W-1:0] DIR_IDX [23] = '{
        32'h00000000, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
        32'h00000001, 32'h80000000, 32'h7FFFFFFF, 32'h12345678,
        32'h000000FA, 32'h000001F4, 32'h000002EE, 32'h000003E8,
        32'hFFFFFF06, 32'h0F0F0F0F, 32'hF0F0F0F0,
        32'h00010000, 32'h000100FA, 32'h000101F4, 32'h000102EE,
        32'h000103E8, 32'h000104E2, 32'h000105DC, 32'h000106D6
    };

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic [dcp_pkg::S_TDATA_W-1:0]      s_tdata   = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [dcp_pkg::M_TDATA_W-1:0]      m_tdata;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [dcp_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [dcp_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

    int                                 pending_results;
    int                                 mismatch_count;
    int                                 cycle_count    = 0;
    int                                 src_idle_pct   = 0;
    int                                 sink_stall_pct = 0;
    logic [dcp_pkg::INDEX_W-1:0]        next_index     = '0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    detection_confirm_policy_unit #(
        .HISTORY_DEPTH(64)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    detection_confirm_policy_checker #(
        .HISTORY_DEPTH(64)
    ) policy_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_reading(input logic [dcp_pkg::CONF_W-1:0] conf,
                                input logic [dcp_pkg::INDEX_W-1:0] idx);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tdata  <= {idx, conf};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender until every predicted decision has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [dcp_pkg::CFG_DATA_W-1:0] thr,
                                  input logic [dcp_pkg::CFG_DATA_W-1:0] mode,
                                  input logic [dcp_pkg::CFG_DATA_W-1:0] win,
                                  input logic [dcp_pkg::CFG_DATA_W-1:0] kneed,
                                  input logic [dcp_pkg::CFG_DATA_W-1:0] cool);
        logic [dcp_pkg::CFG_INDEX_W-1:0] regs [5];
        logic [dcp_pkg::CFG_DATA_W-1:0]  vals [5];
        regs = '{dcp_pkg::REG_THRESHOLD, dcp_pkg::REG_CONFIRM_MODE,
                 dcp_pkg::REG_WINDOW_N, dcp_pkg::REG_NEEDED_K,
                 dcp_pkg::REG_COOLDOWN_LEN};
        vals = '{thr, mode, win, kneed, cool};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // window and k: mostly short, sometimes zero, full, oversize or raw 16 bits
    function automatic logic [dcp_pkg::CFG_DATA_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 60) return cfg_word_t'($urandom_range(1, 8));
        if (r < 75) return cfg_word_t'($urandom_range(9, 63));
        if (r < 85) return 16'd64;
        if (r < 90) return 16'd0;
        if (r < 95) return cfg_word_t'($urandom_range(65, 127));
        return cfg_word_t'($urandom());
    endfunction

    task automatic run_phase(input int readings, input logic max_cooldown);
        logic [dcp_pkg::CFG_DATA_W-1:0] thr;
        logic [dcp_pkg::CFG_DATA_W-1:0] cool;
        logic [dcp_pkg::CONF_W-1:0]     conf;
        int                             r;
        int                             abn_pct;
        logic                           burst;
        r = $urandom_range(99);
        if (r < 15) thr = 16'h0000;
        else if (r < 25) thr = 16'hFFFF;
        else thr = cfg_word_t'($urandom());
        r = $urandom_range(99);
        if (max_cooldown) cool = 16'hFFFF;
        else if (r < 30) cool = 16'd0;
        else if (r < 80) cool = cfg_word_t'($urandom_range(1, 8));
        else cool = cfg_word_t'($urandom_range(9, 60));
        write_settings(thr, cfg_word_t'($urandom()), pick_size(), pick_size(), cool);
        abn_pct = $urandom_range(5, 95);
        burst = 1'b0;
        for (int i = 0; i < readings; i++) begin
            if (i == readings / 2) drain_results();
            // abnormal readings come in runs so k-of-n windows fill up
            if ($urandom_range(99) < 15) burst = ~burst;
            r = $urandom_range(99);
            if (r < 10) begin
                conf = conf_word_t'($urandom());
            end else if ((burst ? 90 : abn_pct / 3) > $urandom_range(99)) begin
                conf = (thr == 16'hFFFF) ? 16'hFFFF
                                         : conf_word_t'($urandom_range(thr + 1, 65535));
            end else begin
                conf = conf_word_t'($urandom_range(0, thr));
            end
            if ($urandom_range(99) < 10) next_index = $urandom();
            else next_index = next_index + 32'd250;
            send_reading(conf, next_index);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, threshold edges and index extremes
        for (int i = 0; i < 8; i++) send_reading(DIR_CONF[i], DIR_IDX[i]);
        // zero threshold, k-of-n via a full-width mode write, zero window,
        // zero k, zero cooldown
        drain_results();
        write_settings(16'h0000, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        for (int i = 8; i < 12; i++) send_reading(DIR_CONF[i], DIR_IDX[i]);
        // oversize window and k above the window, longest cooldown unused
        drain_results();
        write_settings(16'hFFFF, 16'hFFFF, 16'd127, 16'd100, 16'hFFFF);
        for (int i = 12; i < 15; i++) send_reading(DIR_CONF[i], DIR_IDX[i]);
        // window shrunk below position and fill, mode bit 0 of a wider value
        drain_results();
        write_settings(16'h8000, 16'h0002, 16'd3, 16'd2, 16'd2);
        for (int i = 15; i < 23; i++) send_reading(DIR_CONF[i], DIR_IDX[i]);

        next_index = $urandom();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain_results();
            case (phase % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 57;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 57;
                end
                default: begin
                    src_idle_pct   = 22;
                    sink_stall_pct = 22;
                end
            endcase
            run_phase(PHASE_READINGS, phase == PHASE_COUNT - 1);
        end

        drain_results();
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
